// File: sv/backing_store_map_table_core_assert.svh
// Assertion macros used by the backing-store map table core.
`ifndef BACKING_STORE_MAP_TABLE_CORE_ASSERT_SVH
`define BACKING_STORE_MAP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BSMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BSMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bsmt_pkg.sv
// Types and constants of the backing-store map table.
package bsmt_pkg;

   localparam int ENTRIES    = 8;
   localparam int PAGE_SHIFT = 12;
   localparam int IDX_LIMIT  = 8;
   localparam int USABLE     = (ENTRIES < IDX_LIMIT) ? ENTRIES : IDX_LIMIT;
   localparam int SLOT_W     = $clog2(USABLE);

   localparam int CMD_W      = 3;
   localparam int INDEX_W    = 3;
   localparam int OWNER_W    = 6;
   localparam int BASE_W     = 20;
   localparam int COUNT_W    = 9;
   localparam int ADDR_W     = 32;
   localparam int OFF_W      = 8;
   localparam int MAX_COUNT  = 256;
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int DIFF_W     = ((PAGE_W > BASE_W) ? PAGE_W : BASE_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 3'd0,
      CMD_MAP    = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_LOOKUP = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_EXEC
   } state_type;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic                set;
      logic                clr_one;
      logic                clr_all;
      slot_type            idx;
      logic [OWNER_W-1:0]  owner;
      logic [BASE_W-1:0]   base;
      logic [COUNT_W-1:0]  size;
   } tbl_wr_type;

   typedef struct packed {
      logic                valid;
      logic [OWNER_W-1:0]  owner;
      logic [BASE_W-1:0]   base;
      logic [COUNT_W-1:0]  size;
   } tbl_rd_type;

endpackage

// File: sv/backing_store_map_table_core.sv
// Backing-store map table: command sequencer, scan and range check around the entry table.
//
// A command word is taken when start is high and busy is low; busy then stays high until the
// result word is strobed on rsp_valid for one cycle, and the receiver cannot stall it. Map,
// free, clear-all and unknown commands go through the exec state, from which the result word
// is registered. Allocate walks the table one entry per cycle through a single read port and
// compare, and stops at the first free entry or reports full after entry USABLE-1.
// Lookup walks the same way to the first valid entry of the process (a miss if there is none),
// then moves to the check state, where the subtract/compare unit does the range check.
// A new command may start in the cycle the result is strobed.
`include "backing_store_map_table_core_assert.svh"

module backing_store_map_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [bsmt_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bsmt_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [bsmt_pkg::OWNER_W-1:0]   req_proc_id,
   input  logic [bsmt_pkg::BASE_W-1:0]    req_base_page,
   input  logic [bsmt_pkg::COUNT_W-1:0]   req_page_count,
   input  logic [bsmt_pkg::ADDR_W-1:0]    req_virt_addr,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [bsmt_pkg::INDEX_W-1:0]   rsp_entry_out,
   output logic [bsmt_pkg::OFF_W-1:0]     rsp_page_offset
);

   bsmt_pkg::state_type              state_ff, state_in;
   logic [bsmt_pkg::CMD_W-1:0]       cmd_ff;
   logic [bsmt_pkg::INDEX_W-1:0]     idx_ff;
   logic [bsmt_pkg::OWNER_W-1:0]     pid_ff;
   logic [bsmt_pkg::BASE_W-1:0]      base_ff;
   logic [bsmt_pkg::COUNT_W-1:0]     cnt_ff;
   logic [bsmt_pkg::PAGE_W-1:0]      page_ff;
   bsmt_pkg::slot_type               scan_ff, scan_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   bsmt_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [bsmt_pkg::INDEX_W-1:0]     rsp_entry_ff, rsp_entry_in;
   logic [bsmt_pkg::OFF_W-1:0]       rsp_off_ff, rsp_off_in;

   bsmt_pkg::tbl_wr_type             tbl_wr;
   bsmt_pkg::tbl_rd_type             tbl_rd;

   logic                             accept;
   logic                             scan_last;
   logic                             idx_ok;
   logic                             free_hit;
   logic                             own_hit;
   logic [bsmt_pkg::DIFF_W-1:0]      diff;
   logic                             range_hit;

   assign accept    = start && !busy;
   assign busy      = (state_ff != bsmt_pkg::S_IDLE);
   assign scan_last = (scan_ff == bsmt_pkg::slot_type'(bsmt_pkg::USABLE - 1));
   assign idx_ok    = (int'(idx_ff) < bsmt_pkg::USABLE);
   assign free_hit  = !tbl_rd.valid;
   assign own_hit   = tbl_rd.valid && (tbl_rd.owner == pid_ff);

   // range unit: borrow means page below base, low bits vs count gives upper bound
   assign diff      = bsmt_pkg::DIFF_W'(page_ff) - bsmt_pkg::DIFF_W'(tbl_rd.base);
   assign range_hit = !diff[bsmt_pkg::DIFF_W-1] &&
                      (diff[bsmt_pkg::DIFF_W-2:0] <
                       (bsmt_pkg::DIFF_W-1)'(tbl_rd.size));

   bsmt_table u_table (
      .clock  (clock),
      .reset  (reset),
      .wr     (tbl_wr),
      .rd_idx (scan_ff),
      .rd     (tbl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsmt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         idx_ff  <= req_entry_index;
         pid_ff  <= req_proc_id;
         base_ff <= req_base_page;
         cnt_ff  <= req_page_count;
         page_ff <= req_virt_addr[bsmt_pkg::ADDR_W-1:bsmt_pkg::PAGE_SHIFT];
      end
      scan_ff       <= scan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_off_ff    <= rsp_off_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsmt_pkg::S_IDLE: begin
            if (accept) begin
               if ((req_cmd == bsmt_pkg::CMD_ALLOC) || (req_cmd == bsmt_pkg::CMD_LOOKUP)) begin
                  state_in = bsmt_pkg::S_SCAN;
               end else begin
                  state_in = bsmt_pkg::S_EXEC;
               end
            end
         end
         bsmt_pkg::S_SCAN: begin
            if (cmd_ff == bsmt_pkg::CMD_ALLOC) begin
               if (free_hit || scan_last) begin
                  state_in = bsmt_pkg::S_IDLE;
               end
            end else begin
               if (own_hit) begin
                  state_in = bsmt_pkg::S_CHECK;
               end else if (scan_last) begin
                  state_in = bsmt_pkg::S_IDLE;
               end
            end
         end
         bsmt_pkg::S_CHECK: state_in = bsmt_pkg::S_IDLE;
         bsmt_pkg::S_EXEC:  state_in = bsmt_pkg::S_IDLE;
         default:           state_in = bsmt_pkg::S_IDLE;
      endcase
   end

   // datapath controls and result word
   always_comb begin
      scan_in        = scan_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_off_in     = rsp_off_ff;
      tbl_wr         = '0;
      tbl_wr.idx     = idx_ff[bsmt_pkg::SLOT_W-1:0];
      tbl_wr.owner   = pid_ff;
      tbl_wr.base    = base_ff;
      tbl_wr.size    = (int'(cnt_ff) > bsmt_pkg::MAX_COUNT) ?
                       bsmt_pkg::COUNT_W'(bsmt_pkg::MAX_COUNT) : cnt_ff;
      case (state_ff)
         bsmt_pkg::S_IDLE: begin
            scan_in = '0;
         end
         bsmt_pkg::S_SCAN: begin
            if (cmd_ff == bsmt_pkg::CMD_ALLOC) begin
               if (free_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bsmt_pkg::ST_OK;
                  rsp_entry_in  = bsmt_pkg::INDEX_W'(scan_ff);
                  rsp_off_in    = '0;
               end else if (scan_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bsmt_pkg::ST_FULL;
                  rsp_entry_in  = '0;
                  rsp_off_in    = '0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end else begin
               if (own_hit) begin
                  scan_in = scan_ff;
               end else if (scan_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bsmt_pkg::ST_MISS;
                  rsp_entry_in  = '0;
                  rsp_off_in    = '0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         bsmt_pkg::S_CHECK: begin
            // first owned entry decides; no further entries are tried
            rsp_valid_in = 1'b1;
            if (range_hit) begin
               rsp_status_in = bsmt_pkg::ST_OK;
               rsp_entry_in  = bsmt_pkg::INDEX_W'(scan_ff);
               rsp_off_in    = diff[bsmt_pkg::OFF_W-1:0];
            end else begin
               rsp_status_in = bsmt_pkg::ST_MISS;
               rsp_entry_in  = '0;
               rsp_off_in    = '0;
            end
         end
         bsmt_pkg::S_EXEC: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = bsmt_pkg::ST_MISS;
            rsp_entry_in  = '0;
            rsp_off_in    = '0;
            case (cmd_ff)
               bsmt_pkg::CMD_MAP: begin
                  if (idx_ok) begin
                     tbl_wr.set    = 1'b1;
                     rsp_status_in = bsmt_pkg::ST_OK;
                     rsp_entry_in  = idx_ff;
                  end
               end
               bsmt_pkg::CMD_FREE: begin
                  if (idx_ok) begin
                     tbl_wr.clr_one = 1'b1;
                     rsp_status_in  = bsmt_pkg::ST_OK;
                     rsp_entry_in   = idx_ff;
                  end
               end
               bsmt_pkg::CMD_CLEAR: begin
                  tbl_wr.clr_all = 1'b1;
                  rsp_status_in  = bsmt_pkg::ST_OK;
               end
               default: begin
                  rsp_status_in = bsmt_pkg::ST_MISS;
               end
            endcase
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_out   = rsp_entry_ff;
   assign rsp_page_offset = rsp_off_ff;

   `BSMT_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result word while busy")
   `BSMT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word not busy")
   `BSMT_ASSERT_IMP(a_miss_clean, clock, reset, rsp_valid && (rsp_status != bsmt_pkg::ST_OK), (rsp_entry_out == '0) && (rsp_page_offset == '0), "failed word carries data")
   `BSMT_ASSERT_IMP(a_write_exec, clock, reset, tbl_wr.set || tbl_wr.clr_one || tbl_wr.clr_all, state_ff == bsmt_pkg::S_EXEC, "table write outside exec")

endmodule

// File: sv/bsmt_table.sv
// Mapping table storage: valid bits plus owner, base page and page count per entry.
module bsmt_table (
   input  logic                 clock,
   input  logic                 reset,
   input  bsmt_pkg::tbl_wr_type wr,
   input  bsmt_pkg::slot_type   rd_idx,
   output bsmt_pkg::tbl_rd_type rd
);

   logic [bsmt_pkg::USABLE-1:0]  valid_ff;
   logic [bsmt_pkg::OWNER_W-1:0] owner_ff [bsmt_pkg::USABLE];
   logic [bsmt_pkg::BASE_W-1:0]  base_ff  [bsmt_pkg::USABLE];
   logic [bsmt_pkg::COUNT_W-1:0] size_ff  [bsmt_pkg::USABLE];

   always_ff @(posedge clock) begin
      if (reset || wr.clr_all) begin
         valid_ff <= '0;
      end else if (wr.set) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.clr_one) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   // payload is only ever read behind its valid bit
   always_ff @(posedge clock) begin
      if (wr.set) begin
         owner_ff[wr.idx] <= wr.owner;
         base_ff[wr.idx]  <= wr.base;
         size_ff[wr.idx]  <= wr.size;
      end
   end

   assign rd.valid = valid_ff[rd_idx];
   assign rd.owner = owner_ff[rd_idx];
   assign rd.base  = base_ff[rd_idx];
   assign rd.size  = size_ff[rd_idx];

endmodule
